// ===== hdl/twiddle_gain_tuner_assert.svh =====
// ----------------------------------------------------------------------------
// twiddle_gain_tuner_assert.svh
// Assertion macros used by the tuner checker.
// ----------------------------------------------------------------------------
`ifndef TWIDDLE_GAIN_TUNER_ASSERT_SVH
`define TWIDDLE_GAIN_TUNER_ASSERT_SVH

// same-cycle implication
`define TGT_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tuner check failed");

// next-cycle implication
`define TGT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tuner check failed");

// next-cycle implication that also holds through reset
`define TGT_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tuner check failed");

`endif

// ===== hdl/twt_pkg.sv =====
// ----------------------------------------------------------------------------
// twt_pkg
// Widths, codes, reset constants and arithmetic helpers of the gain tuner.
// ----------------------------------------------------------------------------
package twt_pkg;

  localparam int ERROR_ACC_WIDTH_DEF = 48;

  localparam int GAIN_W = 32;
  localparam int CTE_W  = 16;
  localparam int TOL_W  = 34;

  // opcodes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_END_RUN = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [1:0] REG_INIT_KP = 2'd0;
  localparam logic [1:0] REG_INIT_KI = 2'd1;
  localparam logic [1:0] REG_INIT_KD = 2'd2;

  // probed gain
  localparam logic [1:0] GAIN_P = 2'd0;
  localparam logic [1:0] GAIN_D = 2'd1;
  localparam logic [1:0] GAIN_I = 2'd2;

  // probe phase
  localparam logic [1:0] PH_TRY        = 2'd0;
  localparam logic [1:0] PH_JUDGE_UP   = 2'd1;
  localparam logic [1:0] PH_JUDGE_DOWN = 2'd2;

  // Q16.16 step constants and Q1.16 scale factors
  localparam logic [31:0] STEP_P_INIT = 32'd32768;
  localparam logic [31:0] STEP_I_INIT = 32'd66;
  localparam logic [31:0] STEP_D_INIT = 32'd655;
  localparam logic [16:0] GROW_Q16    = 17'd72090;
  localparam logic [16:0] SHRINK_Q16  = 17'd58982;

  // a step never rounds below one LSB, so three steps sum to at least three
  localparam logic [TOL_W-1:0] TOL_FLOOR = 34'd3;

  typedef struct packed {
    logic       fire;
    logic [1:0] opcode;
  } twt_cmd_t;

  function automatic logic signed [31:0] sat_gain(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
      r = x[31:0];
    end else if (x[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [31:0] scale_step(input logic [31:0] s, input logic [16:0] c);
    logic [48:0] prod;
    logic [49:0] rnd;
    logic [31:0] r;
    prod = s * c;
    rnd  = {1'b0, prod} + 50'd32768;
    if (|rnd[49:48]) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = rnd[47:16];
    end
    return r;
  endfunction

endpackage

// ===== hdl/twt_accum.sv =====
// ----------------------------------------------------------------------------
// twt_accum
// Saturating sum of squared error samples for the current run.
// ----------------------------------------------------------------------------
module twt_accum
  import twt_pkg::*;
#(
  parameter int ACC_W = ERROR_ACC_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  twt_cmd_t                cmd,
  input  logic signed [CTE_W-1:0] cte,
  output logic [ACC_W-1:0]        error_sum
);

  logic signed [31:0] sq_s;
  logic [31:0]        sq;
  logic [ACC_W:0]     sum;

  assign sq_s = cte * cte;
  assign sq   = unsigned'(sq_s);
  assign sum  = {1'b0, error_sum} + {{(ACC_W + 1 - 32){1'b0}}, sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum <= '0;
    end else if (cmd.fire) begin
      case (cmd.opcode) inside
        OP_SAMPLE: begin
          error_sum <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        end
        OP_END_RUN, OP_RESTART: begin
          error_sum <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/twt_probe.sv =====
// ----------------------------------------------------------------------------
// twt_probe
// Gains, steps, best run and the three-phase probe of the active gain.
// ----------------------------------------------------------------------------
module twt_probe
  import twt_pkg::*;
#(
  parameter int ACC_W = ERROR_ACC_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  twt_cmd_t                 cmd,
  input  logic [ACC_W-1:0]         error_sum,
  input  logic signed [GAIN_W-1:0] init_kp,
  input  logic signed [GAIN_W-1:0] init_ki,
  input  logic signed [GAIN_W-1:0] init_kd,
  output logic signed [GAIN_W-1:0] gain_p,
  output logic signed [GAIN_W-1:0] gain_i,
  output logic signed [GAIN_W-1:0] gain_d,
  output logic [GAIN_W-1:0]        step_p,
  output logic [GAIN_W-1:0]        step_i,
  output logic [GAIN_W-1:0]        step_d,
  output logic [1:0]               probe_gain,
  output logic [1:0]               probe_phase
);

  logic [ACC_W-1:0]         best_sum;
  logic [ACC_W-1:0]         best_sum_next;
  logic signed [GAIN_W-1:0] gain_p_next;
  logic signed [GAIN_W-1:0] gain_i_next;
  logic signed [GAIN_W-1:0] gain_d_next;
  logic [GAIN_W-1:0]        step_p_next;
  logic [GAIN_W-1:0]        step_i_next;
  logic [GAIN_W-1:0]        step_d_next;
  logic [1:0]               probe_gain_next;
  logic [1:0]               probe_phase_next;

  logic signed [GAIN_W-1:0] g;
  logic [GAIN_W-1:0]        s;
  logic [1:0]               follow;
  logic                     better;
  logic signed [34:0]       g_ext;
  logic signed [GAIN_W-1:0] g_plus;
  logic signed [GAIN_W-1:0] g_minus2;
  logic [GAIN_W-1:0]        s_scaled;
  logic signed [GAIN_W-1:0] g_new;
  logic [GAIN_W-1:0]        s_new;
  logic [1:0]               gain_new;
  logic [1:0]               phase_new;
  logic [ACC_W-1:0]         best_new;

  always_comb begin
    case (probe_gain)
      GAIN_D: begin
        g = gain_d;
        s = step_d;
        follow = GAIN_I;
      end
      GAIN_I: begin
        g = gain_i;
        s = step_i;
        follow = GAIN_P;
      end
      default: begin
        g = gain_p;
        s = step_p;
        follow = GAIN_D;
      end
    endcase
  end

  assign better   = error_sum < best_sum;
  assign g_ext    = {{3{g[GAIN_W-1]}}, g};
  assign g_plus   = sat_gain(g_ext + signed'({3'b000, s}));
  assign g_minus2 = sat_gain(g_ext - signed'({2'b00, s, 1'b0}));
  assign s_scaled = scale_step(s, better ? GROW_Q16 : SHRINK_Q16);

  always_comb begin
    g_new     = g;
    s_new     = s;
    gain_new  = probe_gain;
    phase_new = probe_phase;
    best_new  = best_sum;
    if (probe_phase == PH_TRY) begin
      g_new     = g_plus;
      phase_new = PH_JUDGE_UP;
    end else if (better) begin
      best_new  = error_sum;
      s_new     = s_scaled;
      gain_new  = follow;
      phase_new = PH_TRY;
    end else if (probe_phase == PH_JUDGE_UP) begin
      g_new     = g_minus2;
      phase_new = PH_JUDGE_DOWN;
    end else begin
      g_new     = g_plus;
      s_new     = s_scaled;
      gain_new  = follow;
      phase_new = PH_TRY;
    end
  end

  always_comb begin
    gain_p_next      = gain_p;
    gain_i_next      = gain_i;
    gain_d_next      = gain_d;
    step_p_next      = step_p;
    step_i_next      = step_i;
    step_d_next      = step_d;
    best_sum_next    = best_sum;
    probe_gain_next  = probe_gain;
    probe_phase_next = probe_phase;
    if (cmd.fire) begin
      case (cmd.opcode)
        OP_END_RUN: begin
          case (probe_gain)
            GAIN_D: begin
              gain_d_next = g_new;
              step_d_next = s_new;
            end
            GAIN_I: begin
              gain_i_next = g_new;
              step_i_next = s_new;
            end
            default: begin
              gain_p_next = g_new;
              step_p_next = s_new;
            end
          endcase
          best_sum_next    = best_new;
          probe_gain_next  = gain_new;
          probe_phase_next = phase_new;
        end
        OP_RESTART: begin
          gain_p_next      = init_kp;
          gain_i_next      = init_ki;
          gain_d_next      = init_kd;
          step_p_next      = STEP_P_INIT;
          step_i_next      = STEP_I_INIT;
          step_d_next      = STEP_D_INIT;
          best_sum_next    = '1;
          probe_gain_next  = GAIN_P;
          probe_phase_next = PH_TRY;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      step_p      <= STEP_P_INIT;
      step_i      <= STEP_I_INIT;
      step_d      <= STEP_D_INIT;
      best_sum    <= '1;
      probe_gain  <= GAIN_P;
      probe_phase <= PH_TRY;
    end else begin
      gain_p      <= gain_p_next;
      gain_i      <= gain_i_next;
      gain_d      <= gain_d_next;
      step_p      <= step_p_next;
      step_i      <= step_i_next;
      step_d      <= step_d_next;
      best_sum    <= best_sum_next;
      probe_gain  <= probe_gain_next;
      probe_phase <= probe_phase_next;
    end
  end

endmodule

// ===== hdl/twiddle_gain_tuner.sv =====
// ----------------------------------------------------------------------------
// twiddle_gain_tuner
// Coordinate-descent tuner for three PID gains with a saturating error sum.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    opcode, cte
//   out      out_valid / out_ready  kp, ki, kd, tolerance, active_gain, phase
//   cfg      cfg_wr_en              cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high; a taken beat passes
// the input register, then the state update that also holds the result.
// The result is the tuner state itself, so the state advances only when the
// previous result is taken; one more beat waits in the input register.
// Reset loads zero gains, the initial steps and an empty run.
// ----------------------------------------------------------------------------
module twiddle_gain_tuner
  import twt_pkg::*;
#(
  parameter int ERROR_ACC_WIDTH = ERROR_ACC_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic signed [CTE_W-1:0]  cte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GAIN_W-1:0] kp,
  output logic signed [GAIN_W-1:0] ki,
  output logic signed [GAIN_W-1:0] kd,
  output logic [TOL_W-1:0]         tolerance,
  output logic [1:0]               active_gain,
  output logic [1:0]               phase,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [GAIN_W-1:0]        cfg_data
);

  logic signed [GAIN_W-1:0] init_kp;
  logic signed [GAIN_W-1:0] init_ki;
  logic signed [GAIN_W-1:0] init_kd;

  logic                    stage_valid;
  logic [1:0]              stage_opcode;
  logic signed [CTE_W-1:0] stage_cte;
  logic                    fire;
  twt_cmd_t                cmd;

  logic [ERROR_ACC_WIDTH-1:0] error_sum;
  logic [GAIN_W-1:0]          step_p;
  logic [GAIN_W-1:0]          step_i;
  logic [GAIN_W-1:0]          step_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_kp <= '0;
      init_ki <= '0;
      init_kd <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INIT_KP: init_kp <= cfg_data;
        REG_INIT_KI: init_ki <= cfg_data;
        REG_INIT_KD: init_kd <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign fire     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_opcode <= opcode;
      stage_cte    <= cte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign cmd.fire   = fire;
  assign cmd.opcode = stage_opcode;

  twt_accum #(
    .ACC_W(ERROR_ACC_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cte       (stage_cte),
    .error_sum (error_sum)
  );

  twt_probe #(
    .ACC_W(ERROR_ACC_WIDTH)
  ) u_probe (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .error_sum   (error_sum),
    .init_kp     (init_kp),
    .init_ki     (init_ki),
    .init_kd     (init_kd),
    .gain_p      (kp),
    .gain_i      (ki),
    .gain_d      (kd),
    .step_p      (step_p),
    .step_i      (step_i),
    .step_d      (step_d),
    .probe_gain  (active_gain),
    .probe_phase (phase)
  );

  assign tolerance = {2'b00, step_p} + {2'b00, step_i} + {2'b00, step_d};

endmodule

// ===== hdl/twt_checker.sv =====
// ----------------------------------------------------------------------------
// twt_checker
// Port-level checks of the gain tuner, bound to the top level.
// ----------------------------------------------------------------------------
`include "twiddle_gain_tuner_assert.svh"

module twt_checker
  import twt_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [GAIN_W-1:0] kp,
  input logic signed [GAIN_W-1:0] ki,
  input logic signed [GAIN_W-1:0] kd,
  input logic [TOL_W-1:0]         tolerance,
  input logic [1:0]               active_gain,
  input logic [1:0]               phase
);

  `TGT_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, rst, !out_valid)
  `TGT_ASSERT_SAME(a_tol_floor, clk, rst, out_valid, tolerance >= TOL_FLOOR)
  `TGT_ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `TGT_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && !out_ready, out_valid && $stable(kp) && $stable(ki) && $stable(kd) && $stable(active_gain) && $stable(phase))

endmodule

bind twiddle_gain_tuner twt_checker u_twt_checker (.*);

// ===== tb/sv/twiddle_gain_tuner_tb.sv =====
// ----------------------------------------------------------------------------
// twiddle_gain_tuner_tb
// Self-checking bench for the PID gain tuner. A tracker class mirrors the
// tuner state (gains, steps, error sum, best sum, probe position) and queues
// the state view each accepted beat should produce; every output beat is
// compared field by field against the oldest queued view. Stimulus walks
// every probe branch by hand, pushes full-scale samples back to back, grows
// all three steps over a string of improving runs, then runs random runs of
// samples under several register settings with random gaps, long output
// stalls and drains.
// ----------------------------------------------------------------------------
module twiddle_gain_tuner_tb
  import twt_pkg::*;
();

  typedef struct {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [TOL_W-1:0]         tol;
    logic [1:0]               gain;
    logic [1:0]               phase;
  } tuner_view_t;

  class gain_tracker;
    logic [GAIN_W-1:0]              init_p, init_i, init_d;
    logic signed [GAIN_W-1:0]       gain_p, gain_i, gain_d;
    logic [GAIN_W-1:0]              step_p, step_i, step_d;
    logic [ERROR_ACC_WIDTH_DEF-1:0] err_acc, best_acc;
    logic [1:0]                     probe, phase;
    tuner_view_t                    expected_views[$];
    int                             fails;

    function new();
      init_p = '0;
      init_i = '0;
      init_d = '0;
      fails  = 0;
      restart();
    endfunction

    function void restart();
      gain_p   = init_p;
      gain_i   = init_i;
      gain_d   = init_d;
      step_p   = STEP_P_INIT;
      step_i   = STEP_I_INIT;
      step_d   = STEP_D_INIT;
      err_acc  = '0;
      best_acc = '1;
      probe    = GAIN_P;
      phase    = PH_TRY;
    endfunction

    function void write_reg(logic [1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_INIT_KP: init_p = data;
        REG_INIT_KI: init_i = data;
        REG_INIT_KD: init_d = data;
        default: ;
      endcase
    endfunction

    static function logic signed [GAIN_W-1:0] clamp_gain(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
    endfunction

    static function logic [GAIN_W-1:0] rescale(logic [GAIN_W-1:0] s, logic [16:0] c);
      logic [63:0] p;
      p = (64'(s) * 64'(c) + 64'd32768) >> 16;
      if (p > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
      return p[31:0];
    endfunction

    function void add_sample(logic signed [CTE_W-1:0] e);
      longint      v;
      logic [63:0] sq, mask, room;
      v    = e;
      sq   = v * v;
      mask = (64'd1 << ERROR_ACC_WIDTH_DEF) - 64'd1;
      room = mask - 64'(err_acc);
      err_acc = (sq > room) ? mask[ERROR_ACC_WIDTH_DEF-1:0]
                            : err_acc + sq[ERROR_ACC_WIDTH_DEF-1:0];
    endfunction

    function void end_run();
      logic signed [GAIN_W-1:0] g;
      logic [GAIN_W-1:0]        s;
      logic [1:0]               nxt;
      bit                       better;
      better = err_acc < best_acc;
      case (probe)
        GAIN_D: begin
          g = gain_d; s = step_d; nxt = GAIN_I;
        end
        GAIN_I: begin
          g = gain_i; s = step_i; nxt = GAIN_P;
        end
        default: begin
          g = gain_p; s = step_p; nxt = GAIN_D;
        end
      endcase
      if (phase == PH_TRY) begin
        g = clamp_gain(longint'(g) + longint'(s));
        phase = PH_JUDGE_UP;
      end else if (better) begin
        best_acc = err_acc;
        s = rescale(s, GROW_Q16);
        probe = nxt;
        phase = PH_TRY;
      end else if (phase == PH_JUDGE_UP) begin
        g = clamp_gain(longint'(g) - 2 * longint'(s));
        phase = PH_JUDGE_DOWN;
      end else begin
        g = clamp_gain(longint'(g) + longint'(s));
        s = rescale(s, SHRINK_Q16);
        probe = nxt;
        phase = PH_TRY;
      end
      case (nxt)
        GAIN_I: begin
          gain_d = g; step_d = s;
        end
        GAIN_P: begin
          gain_i = g; step_i = s;
        end
        default: begin
          gain_p = g; step_p = s;
        end
      endcase
      err_acc = '0;
    endfunction

    function void note_beat(logic [1:0] op, logic signed [CTE_W-1:0] e);
      tuner_view_t v;
      case (op)
        OP_SAMPLE:  add_sample(e);
        OP_END_RUN: end_run();
        OP_RESTART: restart();
        default: ;
      endcase
      v.kp    = gain_p;
      v.ki    = gain_i;
      v.kd    = gain_d;
      v.tol   = TOL_W'(step_p) + TOL_W'(step_i) + TOL_W'(step_d);
      v.gain  = probe;
      v.phase = phase;
      expected_views.push_back(v);
    endfunction

    function int pending();
      return expected_views.size();
    endfunction

    function void compare_field(string name, logic signed [TOL_W:0] want,
                                logic signed [TOL_W:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_view(tuner_view_t got);
      tuner_view_t want;
      if (expected_views.size() == 0) begin
        $error("result beat with no pending expectation");
        fails++;
        return;
      end
      want = expected_views.pop_front();
      compare_field("kp", want.kp, got.kp);
      compare_field("ki", want.ki, got.ki);
      compare_field("kd", want.kd, got.kd);
      compare_field("tolerance", want.tol, got.tol);
      compare_field("active_gain", want.gain, got.gain);
      compare_field("phase", want.phase, got.phase);
    endfunction
  endclass

  localparam logic [1:0] OP_IGNORED   = 2'd3;
  localparam logic [1:0] REG_SPARE    = 2'd3;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         LONG_HOLD    = 80;
  localparam int         SAT_SAMPLES  = 16;
  localparam int         CLIMB_ROUNDS = 12;
  localparam int         SEG_BEATS    = 130;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [1:0]               opcode    = OP_SAMPLE;
  logic signed [CTE_W-1:0]  cte       = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic [TOL_W-1:0]         tolerance;
  logic [1:0]               active_gain, phase;
  logic                     cfg_wr_en = 1'b0;
  logic [1:0]               cfg_index = REG_INIT_KP;
  logic [GAIN_W-1:0]        cfg_data  = '0;

  bit          sender_idle   = 1'b1;
  bit          receiver_idle = 1'b1;
  bit          hold_request  = 1'b0;
  int          quiet_cycles  = 0;
  tuner_view_t seen_view;
  gain_tracker tracker;

  twiddle_gain_tuner #(
    .ERROR_ACC_WIDTH(ERROR_ACC_WIDTH_DEF)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .cte        (cte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kp         (kp),
    .ki         (ki),
    .kd         (kd),
    .tolerance  (tolerance),
    .active_gain(active_gain),
    .phase      (phase),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        tracker.note_beat(opcode, cte);
      end
      if (out_valid && out_ready) begin
        seen_view.kp    = kp;
        seen_view.ki    = ki;
        seen_view.kd    = kd;
        seen_view.tol   = tolerance;
        seen_view.gain  = active_gain;
        seen_view.phase = phase;
        tracker.check_view(seen_view);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : receiver
    int wait_cycles;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      wait_cycles = receiver_idle ? $urandom_range(3, 0) : 0;
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic signed [CTE_W-1:0] val);
    int gap;
    gap = sender_idle ? $urandom_range(3, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    cte      <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the input until every queued view has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_gains(input logic [GAIN_W-1:0] p, i, d);
    logic [GAIN_W-1:0] junk;
    junk = $urandom;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_INIT_KP;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= REG_INIT_KI;
    cfg_data  <= i;
    @(posedge clk);
    cfg_index <= REG_INIT_KD;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    tracker.write_reg(REG_INIT_KP, p);
    tracker.write_reg(REG_INIT_KI, i);
    tracker.write_reg(REG_INIT_KD, d);
    tracker.write_reg(REG_SPARE, junk);
  endtask

  function automatic logic signed [CTE_W-1:0] pick_error();
    int r;
    r = $urandom_range(9, 0);
    if (r < 4) return CTE_W'($urandom);
    if (r < 8) return CTE_W'($urandom_range(128, 0) - 64);
    return (r == 8) ? 16'sh8000 : 16'sh7FFF;
  endfunction

  initial begin : stimulus
    logic signed [CTE_W-1:0] e;
    int                      sent, pick, n;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    program_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);

    // every probe branch from the reset state
    send_beat(OP_IGNORED, 16'sh7FFF);
    send_beat(OP_SAMPLE, 16'sh8000);
    send_beat(OP_SAMPLE, 16'sh7FFF);
    send_beat(OP_SAMPLE, 16'sd0);
    send_beat(OP_SAMPLE, -16'sd1);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_SAMPLE, 16'sd100);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_END_RUN, -16'sd1);
    send_beat(OP_SAMPLE, 16'sd200);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_IGNORED, 16'sd0);
    send_beat(OP_SAMPLE, 16'sd50);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_SAMPLE, -16'sd10);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_RESTART, 16'sh8000);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_SAMPLE, 16'sd1);
    send_beat(OP_END_RUN, 16'sd0);
    drain();

    // full-scale samples back to back, then push kp below its floor
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    program_gains(32'h8000_0100, 32'h7FFF_FF00, 32'h0000_0000);
    send_beat(OP_RESTART, 16'sd0);
    send_beat(OP_END_RUN, 16'sd0);
    repeat (SAT_SAMPLES) send_beat(OP_SAMPLE, 16'sh8000);
    send_beat(OP_END_RUN, 16'sd0);
    send_beat(OP_END_RUN, 16'sd0);
    repeat (6) send_beat(OP_END_RUN, 16'sd0);
    drain();

    // improve every climbing run so all three steps grow, then stop improving
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    program_gains($urandom, $urandom, $urandom);
    send_beat(OP_RESTART, 16'sd0);
    e = 16'sh7FFF;
    repeat (CLIMB_ROUNDS * 3) begin
      send_beat(OP_END_RUN, CTE_W'($urandom));
      send_beat(OP_SAMPLE, e);
      send_beat(OP_END_RUN, CTE_W'($urandom));
      e = e - 16'sd1;
    end
    repeat (6) begin
      send_beat(OP_END_RUN, CTE_W'($urandom));
      send_beat(OP_SAMPLE, 16'sh7FFF);
      send_beat(OP_END_RUN, CTE_W'($urandom));
      send_beat(OP_SAMPLE, 16'sh7FFF);
      send_beat(OP_END_RUN, CTE_W'($urandom));
    end
    drain();

    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          program_gains(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
          sender_idle   = 1'b1;
          receiver_idle = 1'b1;
          hold_request  = 1'b1;
        end
        1: begin
          program_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
          sender_idle   = 1'b0;
          receiver_idle = 1'b1;
        end
        2: begin
          program_gains($urandom, $urandom, $urandom);
          sender_idle   = 1'b0;
          receiver_idle = 1'b0;
        end
        default: begin
          program_gains(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
          sender_idle   = 1'b1;
          receiver_idle = 1'b0;
          hold_request  = 1'b1;
        end
      endcase
      send_beat(OP_RESTART, CTE_W'($urandom));
      sent = 0;
      while (sent < SEG_BEATS) begin
        pick = $urandom_range(99, 0);
        if (pick < 4) begin
          send_beat(OP_RESTART, CTE_W'($urandom));
          sent++;
        end else if (pick < 7) begin
          send_beat(OP_IGNORED, CTE_W'($urandom));
        end else if (pick < 12) begin
          send_beat(2'($urandom), pick_error());
          sent++;
        end else begin
          n = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(4, 1);
          repeat (n) send_beat(OP_SAMPLE, pick_error());
          send_beat(OP_END_RUN, CTE_W'($urandom));
          sent += n + 1;
        end
      end
      drain();
    end

    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
